@@ sv/risc16_execute_unit_macros.svh @@
// Assertion macros for the checker of the execute unit.
`ifndef RISC16_EXECUTE_UNIT_MACROS_SVH
`define RISC16_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define R16X_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define R16X_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/r16x_pkg.sv @@
// Types and operation codes shared by the 16-bit execute unit.
package r16x_pkg;

	typedef enum logic [5:0] {
		F_ADD   = 6'd0,
		F_SUB   = 6'd1,
		F_AND   = 6'd2,
		F_OR    = 6'd3,
		F_XOR   = 6'd4,
		F_SLT   = 6'd5,
		F_SLTU  = 6'd6,
		F_SLL   = 6'd7,
		F_SRL   = 6'd8,
		F_SRA   = 6'd9,
		F_MV    = 6'd10,
		F_JR    = 6'd11,
		F_JALR  = 6'd12,
		F_ADDI  = 6'd13,
		F_LI    = 6'd14,
		F_SLTI  = 6'd15,
		F_SLTUI = 6'd16,
		F_SLLI  = 6'd17,
		F_SRLI  = 6'd18,
		F_SRAI  = 6'd19,
		F_ORI   = 6'd20,
		F_ANDI  = 6'd21,
		F_XORI  = 6'd22,
		F_SW    = 6'd23,
		F_SB    = 6'd24,
		F_LW    = 6'd25,
		F_LB    = 6'd26,
		F_LBU   = 6'd27,
		F_BEQ   = 6'd28,
		F_BNE   = 6'd29,
		F_BZ    = 6'd30,
		F_BNZ   = 6'd31,
		F_BLT   = 6'd32,
		F_BGE   = 6'd33,
		F_BLTU  = 6'd34,
		F_BGEU  = 6'd35,
		F_JAL   = 6'd36,
		F_LUI   = 6'd37,
		F_AUIPC = 6'd38,
		F_ECALL = 6'd39
	} func_t;

	typedef enum logic [1:0] {
		LD_NONE = 2'd0,
		LD_W    = 2'd1,
		LD_B    = 2'd2,
		LD_BU   = 2'd3
	} ld_kind_t;

	typedef struct packed {
		logic [5:0]         func;
		logic [2:0]         dest_reg;
		logic [2:0]         src1_reg;
		logic [2:0]         src2_reg;
		logic signed [15:0] immediate;
		logic [15:0]        pc_in;
	} req_t;

	typedef struct packed {
		logic [15:0] pc_out;
		logic        redirected;
		logic        halt;
		logic        wb_enable;
		logic [2:0]  wb_index;
		logic [15:0] wb_value;
	} res_t;

	// Outcome of one instruction before any load data is known.
	typedef struct packed {
		logic [15:0] npc;
		logic        redir;
		logic        halt;
		logic        wb;
		logic [2:0]  rd;
		logic [15:0] val;
		logic        mem_rd;
		logic        we_lo;
		logic        we_hi;
		logic [15:0] addr;
		logic [15:0] wdata;
		ld_kind_t    ld;
	} exe_t;

endpackage

@@ sv/r16x_regfile.sv @@
// Register file with two write-through registered read ports and reset-clear valid bits.
module r16x_regfile import r16x_pkg::*; #(
	parameter int REG_COUNT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(REG_COUNT)-1:0] rd_addr_a,
	input  logic [$clog2(REG_COUNT)-1:0] rd_addr_b,
	output logic [15:0]                  rd_data_a,
	output logic [15:0]                  rd_data_b,
	input  logic                         wr_en,
	input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
	input  logic [15:0]                  wr_data
);

	logic [15:0]          rf_q [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [15:0]          rd_data_a_q;
	logic [15:0]          rd_data_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// An entry never written since reset reads as zero; a write in the same
	// cycle passes straight through to the read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr_a) begin
				rd_data_a_q <= wr_data;
			end else if (vld_q[rd_addr_a]) begin
				rd_data_a_q <= rf_q[rd_addr_a];
			end else begin
				rd_data_a_q <= '0;
			end
			if (wr_en && wr_addr == rd_addr_b) begin
				rd_data_b_q <= wr_data;
			end else if (vld_q[rd_addr_b]) begin
				rd_data_b_q <= rf_q[rd_addr_b];
			end else begin
				rd_data_b_q <= '0;
			end
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

@@ sv/r16x_dmem.sv @@
// Byte-addressed data memory as two byte banks, with a clearing pass after reset.
module r16x_dmem import r16x_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         we_lo,
	input  logic                         we_hi,
	input  logic [$clog2(MEM_BYTES)-2:0] row,
	input  logic [15:0]                  wdata,
	output logic [15:0]                  rdata,
	output logic                         busy
);

	localparam int RW   = $clog2(MEM_BYTES) - 1;
	localparam int ROWS = MEM_BYTES / 2;

	logic [7:0]    bank_lo_q [ROWS];
	logic [7:0]    bank_hi_q [ROWS];
	logic [RW-1:0] clr_row_q;
	logic          clr_busy_q;
	logic [15:0]   rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == RW'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			bank_lo_q[clr_row_q] <= '0;
			bank_hi_q[clr_row_q] <= '0;
		end else if (en) begin
			if (we_lo) begin
				bank_lo_q[row] <= wdata[7:0];
			end
			if (we_hi) begin
				bank_hi_q[row] <= wdata[15:8];
			end
			if (!we_lo && !we_hi) begin
				rdata_q <= {bank_hi_q[row], bank_lo_q[row]};
			end
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

@@ sv/r16x_alu.sv @@
// Execute logic: ALU, compares, shifts, branch and jump targets, memory address and strobes.
module r16x_alu import r16x_pkg::*; (
	input  req_t        instr,
	input  logic [15:0] a,
	input  logic [15:0] b,
	output exe_t        exe
);

	logic [15:0] imm;
	logic [15:0] sum_ai;
	logic [15:0] sum_bi;
	logic [15:0] pc_rel;
	logic [15:0] br_tgt;
	logic [3:0]  sh_b;
	logic [3:0]  sh_i;
	logic        take;

	assign imm    = instr.immediate;
	assign sum_ai = a + imm;
	assign sum_bi = b + imm;
	assign pc_rel = instr.pc_in - 16'd2 + imm;
	assign br_tgt = instr.pc_in + imm;
	assign sh_b   = b[3:0];
	assign sh_i   = imm[3:0];

	always_comb begin
		case (instr.func)
			F_BEQ:   take = (a == b);
			F_BNE:   take = (a != b);
			F_BZ:    take = (a == 16'd0);
			F_BNZ:   take = (a != 16'd0);
			F_BLT:   take = ($signed(a) < $signed(b));
			F_BGE:   take = ($signed(a) >= $signed(b));
			F_BLTU:  take = (a < b);
			F_BGEU:  take = (a >= b);
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		exe        = '0;
		exe.npc    = instr.pc_in;
		exe.ld     = LD_NONE;
		exe.addr   = sum_bi;
		exe.wdata  = b;
		case (instr.func)
			F_ADD:   begin exe.val = a + b;                     exe.wb = 1'b1; end
			F_SUB:   begin exe.val = a - b;                     exe.wb = 1'b1; end
			F_AND:   begin exe.val = a & b;                     exe.wb = 1'b1; end
			F_OR:    begin exe.val = a | b;                     exe.wb = 1'b1; end
			F_XOR:   begin exe.val = a ^ b;                     exe.wb = 1'b1; end
			F_SLT:   begin exe.val = 16'($signed(a) < $signed(b)); exe.wb = 1'b1; end
			F_SLTU:  begin exe.val = 16'(a < b);                exe.wb = 1'b1; end
			F_SLL:   begin exe.val = a << sh_b;                 exe.wb = 1'b1; end
			F_SRL:   begin exe.val = a >> sh_b;                 exe.wb = 1'b1; end
			F_SRA:   begin exe.val = 16'($signed(a) >>> sh_b);  exe.wb = 1'b1; end
			F_MV:    begin exe.val = b;                         exe.wb = 1'b1; end
			// The jump register arrives on the second read port.
			F_JR:    begin exe.npc = b; exe.redir = 1'b1; end
			F_JALR:  begin
				exe.npc   = b;
				exe.redir = 1'b1;
				exe.val   = instr.pc_in;
				exe.wb    = 1'b1;
			end
			F_ADDI:  begin exe.val = sum_ai;                    exe.wb = 1'b1; end
			F_LI:    begin exe.val = imm;                       exe.wb = 1'b1; end
			F_SLTI:  begin exe.val = 16'($signed(a) < $signed(imm)); exe.wb = 1'b1; end
			F_SLTUI: begin exe.val = 16'(a < imm);              exe.wb = 1'b1; end
			F_SLLI:  begin exe.val = a << sh_i;                 exe.wb = 1'b1; end
			F_SRLI:  begin exe.val = a >> sh_i;                 exe.wb = 1'b1; end
			F_SRAI:  begin exe.val = 16'($signed(a) >>> sh_i);  exe.wb = 1'b1; end
			F_ORI:   begin exe.val = a | imm;                   exe.wb = 1'b1; end
			F_ANDI:  begin exe.val = a & imm;                   exe.wb = 1'b1; end
			F_XORI:  begin exe.val = a ^ imm;                   exe.wb = 1'b1; end
			F_SW:    begin
				exe.addr = sum_ai;
				if (sum_ai[0]) begin
					exe.halt = 1'b1;
				end else begin
					exe.we_lo = 1'b1;
					exe.we_hi = 1'b1;
				end
			end
			F_SB:    begin
				exe.addr  = sum_ai;
				exe.wdata = {b[7:0], b[7:0]};
				exe.we_lo = !sum_ai[0];
				exe.we_hi = sum_ai[0];
			end
			F_LW:    begin
				if (sum_bi[0]) begin
					exe.halt = 1'b1;
				end else begin
					exe.mem_rd = 1'b1;
					exe.ld     = LD_W;
					exe.wb     = 1'b1;
				end
			end
			F_LB:    begin exe.mem_rd = 1'b1; exe.ld = LD_B;  exe.wb = 1'b1; end
			F_LBU:   begin exe.mem_rd = 1'b1; exe.ld = LD_BU; exe.wb = 1'b1; end
			F_BEQ, F_BNE, F_BZ, F_BNZ, F_BLT, F_BGE, F_BLTU, F_BGEU: begin
				if (take) begin
					exe.npc   = br_tgt;
					exe.redir = 1'b1;
				end
			end
			F_JAL:   begin
				exe.npc   = pc_rel;
				exe.redir = 1'b1;
				if (instr.dest_reg != 3'd0) begin
					exe.val = instr.pc_in;
					exe.wb  = 1'b1;
				end
			end
			F_LUI:   begin exe.val = imm;    exe.wb = 1'b1; end
			F_AUIPC: begin exe.val = pc_rel; exe.wb = 1'b1; end
			default: exe.halt = 1'b1;
		endcase
		exe.rd = exe.wb ? instr.dest_reg : 3'd0;
	end

endmodule

@@ sv/risc16_execute_unit.sv @@
// Execute stage of a 16-bit integer core: register file, data memory and result register.
//
// Usage: one decoded instruction arrives per request on req (req_valid/req_stall);
// one result leaves per request on res (res_valid/res_stall), in request order.
// The unit accepts one request per cycle while req_stall is low. A result becomes
// valid once its request has passed the registered register-file read and then
// the registered data-memory read, with execution between them.
// Back-to-back dependent instructions need no gaps; results still in the pipe are
// forwarded to the operands of the next instruction.
// Reset clears the register file (through per-register valid bits) and then sweeps
// the data memory, one halfword row per cycle, through all MEM_BYTES/2 rows (32768 by
// default), during which req_stall stays high.
// When the receiver stalls, the result holds on res and a second request can still
// enter behind it; a third is stalled until the result is taken.
// Register writes and memory writes happen in request order; a halting instruction
// writes nothing.
module risc16_execute_unit import r16x_pkg::*; #(
	parameter int REG_COUNT = 8,
	parameter int MEM_BYTES = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int IW = $clog2(REG_COUNT);
	localparam int AW = $clog2(MEM_BYTES);

	logic        valid_s1;
	req_t        req_s1;
	logic        valid_s2;
	exe_t        exe_s2;

	logic        req_acc;
	logic        s1_adv;
	logic        res_acc;
	logic        mem_busy;
	logic [2:0]  rd_b_sel;
	logic [15:0] rf_a;
	logic [15:0] rf_b;
	logic [15:0] opnd_a;
	logic [15:0] opnd_b;
	logic [2:0]  port_b_s1;
	exe_t        exe;
	logic [15:0] mem_rdata;
	logic [7:0]  ld_byte;
	logic [15:0] wb_val;

	assign res_acc   = valid_s2 && !res_stall;
	assign s1_adv    = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = mem_busy || (valid_s1 && !s1_adv);
	assign req_acc   = req_valid && !req_stall;

	// JR reads its target from the destination field on the second port.
	assign rd_b_sel  = (req.func == F_JR) ? req.dest_reg : req.src2_reg;
	assign port_b_s1 = (req_s1.func == F_JR) ? req_s1.dest_reg : req_s1.src2_reg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (res_acc) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
		end
		if (s1_adv) begin
			exe_s2 <= exe;
		end
	end

	r16x_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (req_acc),
		.rd_addr_a (IW'(req.src1_reg)),
		.rd_addr_b (IW'(rd_b_sel)),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr_en     (res_acc && exe_s2.wb),
		.wr_addr   (IW'(exe_s2.rd)),
		.wr_data   (wb_val)
	);

	// The instruction ahead in the result register has not written back yet.
	assign opnd_a = (valid_s2 && exe_s2.wb && exe_s2.rd == req_s1.src1_reg) ? wb_val : rf_a;
	assign opnd_b = (valid_s2 && exe_s2.wb && exe_s2.rd == port_b_s1) ? wb_val : rf_b;

	r16x_alu u_alu (
		.instr (req_s1),
		.a     (opnd_a),
		.b     (opnd_b),
		.exe   (exe)
	);

	r16x_dmem #(
		.MEM_BYTES(MEM_BYTES)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (s1_adv && (exe.mem_rd || exe.we_lo || exe.we_hi)),
		.we_lo  (exe.we_lo),
		.we_hi  (exe.we_hi),
		.row    (exe.addr[AW-1:1]),
		.wdata  (exe.wdata),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	assign ld_byte = exe_s2.addr[0] ? mem_rdata[15:8] : mem_rdata[7:0];

	always_comb begin
		case (exe_s2.ld)
			LD_W:    wb_val = mem_rdata;
			LD_B:    wb_val = {{8{ld_byte[7]}}, ld_byte};
			LD_BU:   wb_val = {8'd0, ld_byte};
			default: wb_val = exe_s2.val;
		endcase
	end

	assign res_valid      = valid_s2;
	assign res.pc_out     = exe_s2.npc;
	assign res.redirected = exe_s2.redir;
	assign res.halt       = exe_s2.halt;
	assign res.wb_enable  = exe_s2.wb;
	assign res.wb_index   = exe_s2.rd;
	assign res.wb_value   = wb_val;

endmodule

@@ sv/r16x_checker.sv @@
// Port-level checker for the execute unit and its bind to the top level.
`include "risc16_execute_unit_macros.svh"

module r16x_checker import r16x_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	`R16X_ASSERT_NEXT(a_res_hold, clk, arst_n,
		res_valid && res_stall,
		res_valid && $stable(res),
		"stalled result changed")

	`R16X_ASSERT_IMPLY(a_no_wb_zero, clk, arst_n,
		res_valid && !res.wb_enable,
		res.wb_index == 3'd0 && res.wb_value == 16'd0,
		"write-back fields set without a write")

	`R16X_ASSERT_IMPLY(a_halt_quiet, clk, arst_n,
		res_valid && res.halt,
		!res.wb_enable && !res.redirected,
		"halting result also writes or redirects")

	`R16X_ASSERT_IMPLY(a_res_latency, clk, arst_n,
		$rose(res_valid),
		$past(req_valid && !req_stall, 2),
		"result appeared without a request two cycles before")

endmodule

bind risc16_execute_unit r16x_checker u_r16x_checker (.*);
